// ===== rtl/core/dtio_pkg.sv =====
// dtio_pkg: payload types and register codes for the dual timer io peripheral
// no dependencies
`timescale 1ns / 1ps

package dtio_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_LINES = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        REG_PRA   = 4'd0,
        REG_PRB   = 4'd1,
        REG_DDRA  = 4'd2,
        REG_DDRB  = 4'd3,
        REG_TALO  = 4'd4,
        REG_TAHI  = 4'd5,
        REG_TBLO  = 4'd6,
        REG_TBHI  = 4'd7,
        REG_TOD0  = 4'd8,
        REG_TOD1  = 4'd9,
        REG_TOD2  = 4'd10,
        REG_TOD3  = 4'd11,
        REG_SDR   = 4'd12,
        REG_ICR   = 4'd13,
        REG_CRA   = 4'd14,
        REG_CRB   = 4'd15
    } reg_addr_t;

    localparam int CR_START    = 0;
    localparam int CR_ONESHOT  = 3;
    localparam int CR_LOAD     = 4;
    localparam int CRA_CNTMODE = 5;
    localparam int CRA_SPOUT   = 6;

    localparam logic [1:0] TB_CLK    = 2'd0;
    localparam logic [1:0] TB_CNT    = 2'd1;
    localparam logic [1:0] TB_TA     = 2'd2;
    localparam logic [1:0] TB_TA_CNT = 2'd3;

    localparam logic [4:0] IRQ_TA   = 5'h01;
    localparam logic [4:0] IRQ_TB   = 5'h02;
    localparam logic [4:0] IRQ_SDR  = 5'h08;
    localparam logic [4:0] IRQ_FLAG = 5'h10;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] address;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       cnt_level;
        logic       sp_level;
        logic       flag_level;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_active;
        logic       shift_out_bit;
        logic       shift_out_strobe;
        logic       shift_out_done;
        logic [7:0] port_a_drive;
        logic [7:0] port_a_direction;
        logic [7:0] port_b_drive;
        logic [7:0] port_b_direction;
    } out_item_t;

    // timer state handed to and from the timer step logic
    typedef struct packed {
        logic [15:0] count;
        logic [15:0] view;
        logic        run;
        logic [7:0]  ctrl;
    } tmr_state_t;

endpackage

// ===== rtl/core/dtio_timer_step.sv =====
// dtio_timer_step: one decrement of a 16-bit timer with reload and one-shot stop
// depends on dtio_pkg
`timescale 1ns / 1ps

module dtio_timer_step (
    input  dtio_pkg::tmr_state_t cur,
    input  logic [15:0]          latch,
    input  logic                 dec,
    output dtio_pkg::tmr_state_t nxt,
    output logic                 under
);
    always_comb begin
        nxt   = cur;
        under = dec && (cur.count == 16'd0);
        if (dec) begin
            nxt.count = cur.count - 16'd1;
            if (under) begin
                nxt.count = latch;
                if (cur.ctrl[dtio_pkg::CR_ONESHOT]) begin
                    nxt.run = 1'b0;
                    nxt.ctrl[dtio_pkg::CR_START] = 1'b0;
                end
            end
            nxt.view = nxt.count;
        end
    end
endmodule

// ===== rtl/core/dual_timer_io_peripheral.sv =====
// dual_timer_io_peripheral: 6526-style adapter with two timers, shifter, irq latch
// depends on dtio_pkg and dtio_timer_step
// result is registered and valid in the cycle after the input transfer
// throughput: one item per cycle while the output register is empty or m_ready is high, state updated in a single pass
// output register holds a result while m_ready is low; s_ready follows it
// reset: synchronous active low, all registers except m_data_reg to their documented values
`timescale 1ns / 1ps

module dual_timer_io_peripheral (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dtio_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dtio_pkg::out_item_t   m_data
);
    logic [7:0]  pa_out_reg, pb_out_reg, dir_a_reg, dir_b_reg, pins_a_reg, pins_b_reg;
    logic [15:0] latch_a_reg, latch_b_reg;
    dtio_pkg::tmr_state_t ta_reg, tb_reg;
    logic [7:0]  tod_reg [4];
    logic [7:0]  sdr_reg, shifter_reg;
    logic [3:0]  scount_reg;
    logic        sloaded_reg;
    logic [4:0]  ien_reg;
    logic [7:0]  ilatch_reg;
    logic        cnt_now_reg, cnt_prev_reg, sp_now_reg, flag_prev_reg;
    logic        m_valid_reg;
    dtio_pkg::out_item_t m_data_reg;

    logic [7:0]  pa_out_next, pb_out_next, dir_a_next, dir_b_next, pins_a_next, pins_b_next;
    logic [15:0] latch_a_next, latch_b_next;
    dtio_pkg::tmr_state_t ta_next, tb_next, ta_stepped, tb_stepped, tb_in;
    logic [7:0]  sdr_next, shifter_next;
    logic [3:0]  scount_next;
    logic        sloaded_next;
    logic [4:0]  ien_next, raise;
    logic [7:0]  ilatch_next;
    logic        cnt_now_next, cnt_prev_next, sp_now_next, flag_prev_next;
    logic [3:0]  tod_wsel;
    dtio_pkg::out_item_t res;

    logic is_tick, cnt_edge, dec_a, dec_b, ua, ub;

    assign s_ready = !m_valid_reg || m_ready;
    logic take;
    assign take = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign is_tick  = s_data.command == dtio_pkg::CMD_TICK;
    assign cnt_edge = cnt_now_reg && !cnt_prev_reg;
    assign dec_a    = is_tick && ta_reg.run &&
                      (!ta_reg.ctrl[dtio_pkg::CRA_CNTMODE] || cnt_edge);

    dtio_timer_step u_ta (
        .cur(ta_reg), .latch(latch_a_reg), .dec(dec_a), .nxt(ta_stepped), .under(ua)
    );

    always_comb begin
        dec_b = 1'b0;
        if (is_tick && tb_reg.run) begin
            case (tb_reg.ctrl[6:5])
                dtio_pkg::TB_CLK: dec_b = 1'b1;
                dtio_pkg::TB_CNT: dec_b = cnt_edge;
                dtio_pkg::TB_TA:  dec_b = ua;
                default:          dec_b = ua && cnt_now_reg;
            endcase
        end
    end

    assign tb_in = tb_reg;
    dtio_timer_step u_tb (
        .cur(tb_in), .latch(latch_b_reg), .dec(dec_b), .nxt(tb_stepped), .under(ub)
    );

    // main state update; raise collects sources, master recomputed at the end
    always_comb begin
        logic [7:0] base_latch;
        logic       recompute;
        logic       icr_read;
        logic [4:0] pend;
        pa_out_next = pa_out_reg;  pb_out_next = pb_out_reg;
        dir_a_next = dir_a_reg;    dir_b_next = dir_b_reg;
        pins_a_next = pins_a_reg;  pins_b_next = pins_b_reg;
        latch_a_next = latch_a_reg; latch_b_next = latch_b_reg;
        ta_next = ta_reg;          tb_next = tb_reg;
        sdr_next = sdr_reg;        shifter_next = shifter_reg;
        scount_next = scount_reg;  sloaded_next = sloaded_reg;
        ien_next = ien_reg;
        cnt_now_next = cnt_now_reg; cnt_prev_next = cnt_prev_reg;
        sp_now_next = sp_now_reg;  flag_prev_next = flag_prev_reg;
        tod_wsel = 4'd0;
        raise = 5'd0;
        recompute = 1'b0;
        icr_read = 1'b0;
        base_latch = ilatch_reg;
        res = '0;
        res.read_data = 8'hFF;
        pend = ilatch_reg[4:0];

        case (s_data.command)
            dtio_pkg::CMD_TICK: begin
                ta_next = ta_stepped;
                tb_next = tb_stepped;
                if (ua) raise = raise | dtio_pkg::IRQ_TA;
                if (ub) raise = raise | dtio_pkg::IRQ_TB;
                if (ta_reg.ctrl[dtio_pkg::CRA_SPOUT] && sloaded_reg && ua) begin
                    res.shift_out_bit    = shifter_reg[7];
                    res.shift_out_strobe = 1'b1;
                    shifter_next = {shifter_reg[6:0], 1'b0};
                    scount_next  = scount_reg + 4'd1;
                    if (scount_next >= 4'd8) begin
                        res.shift_out_done = 1'b1;
                        raise = raise | dtio_pkg::IRQ_SDR;
                        scount_next  = 4'd0;
                        sloaded_next = 1'b0;
                    end
                end
                cnt_prev_next = cnt_now_reg;
            end
            dtio_pkg::CMD_READ: begin
                case (s_data.address)
                    dtio_pkg::REG_PRA:  res.read_data = (pa_out_reg & dir_a_reg) |
                                                        (pins_a_reg & ~dir_a_reg);
                    dtio_pkg::REG_PRB:  res.read_data = (pb_out_reg & dir_b_reg) |
                                                        (pins_b_reg & ~dir_b_reg);
                    dtio_pkg::REG_DDRA: res.read_data = dir_a_reg;
                    dtio_pkg::REG_DDRB: res.read_data = dir_b_reg;
                    dtio_pkg::REG_TALO: res.read_data = ta_reg.view[7:0];
                    dtio_pkg::REG_TAHI: res.read_data = ta_reg.view[15:8];
                    dtio_pkg::REG_TBLO: res.read_data = tb_reg.view[7:0];
                    dtio_pkg::REG_TBHI: res.read_data = tb_reg.view[15:8];
                    dtio_pkg::REG_TOD0: res.read_data = tod_reg[0];
                    dtio_pkg::REG_TOD1: res.read_data = tod_reg[1];
                    dtio_pkg::REG_TOD2: res.read_data = tod_reg[2];
                    dtio_pkg::REG_TOD3: res.read_data = tod_reg[3];
                    dtio_pkg::REG_SDR:  res.read_data = sdr_reg;
                    dtio_pkg::REG_ICR: begin
                        res.read_data = {|(pend & ien_reg), 2'b00, pend};
                        icr_read = 1'b1;
                    end
                    dtio_pkg::REG_CRA:  res.read_data = ta_reg.ctrl;
                    default:            res.read_data = tb_reg.ctrl;
                endcase
            end
            dtio_pkg::CMD_WRITE: begin
                case (s_data.address)
                    dtio_pkg::REG_PRA:  pa_out_next = s_data.write_data;
                    dtio_pkg::REG_PRB:  pb_out_next = s_data.write_data;
                    dtio_pkg::REG_DDRA: dir_a_next = s_data.write_data;
                    dtio_pkg::REG_DDRB: dir_b_next = s_data.write_data;
                    dtio_pkg::REG_TALO: begin
                        ta_next.view[7:0] = s_data.write_data;
                        latch_a_next[7:0] = s_data.write_data;
                        if (!ta_reg.run) ta_next.count[7:0] = s_data.write_data;
                    end
                    dtio_pkg::REG_TAHI: begin
                        ta_next.view[15:8] = s_data.write_data;
                        latch_a_next = {s_data.write_data, ta_reg.view[7:0]};
                        if (!ta_reg.run) ta_next.count = latch_a_next;
                    end
                    dtio_pkg::REG_TBLO: begin
                        tb_next.view[7:0] = s_data.write_data;
                        latch_b_next[7:0] = s_data.write_data;
                        if (!tb_reg.run) tb_next.count[7:0] = s_data.write_data;
                    end
                    dtio_pkg::REG_TBHI: begin
                        tb_next.view[15:8] = s_data.write_data;
                        latch_b_next = {s_data.write_data, tb_reg.view[7:0]};
                        if (!tb_reg.run) tb_next.count = latch_b_next;
                    end
                    dtio_pkg::REG_TOD0: tod_wsel = 4'b0001;
                    dtio_pkg::REG_TOD1: tod_wsel = 4'b0010;
                    dtio_pkg::REG_TOD2: tod_wsel = 4'b0100;
                    dtio_pkg::REG_TOD3: tod_wsel = 4'b1000;
                    dtio_pkg::REG_SDR: begin
                        sdr_next = s_data.write_data;
                        shifter_next = s_data.write_data;
                        scount_next = 4'd0;
                        sloaded_next = 1'b1;
                        cnt_prev_next = cnt_now_reg;
                    end
                    dtio_pkg::REG_ICR: begin
                        if (s_data.write_data[7])
                            ien_next = ien_reg | s_data.write_data[4:0];
                        else
                            ien_next = ien_reg & ~s_data.write_data[4:0];
                        recompute = 1'b1;
                    end
                    dtio_pkg::REG_CRA: begin
                        ta_next.ctrl = s_data.write_data;
                        ta_next.run  = s_data.write_data[dtio_pkg::CR_START];
                        if ((!ta_reg.ctrl[dtio_pkg::CR_START] &&
                             s_data.write_data[dtio_pkg::CR_START]) ||
                            s_data.write_data[dtio_pkg::CR_LOAD])
                            ta_next.count = latch_a_reg;
                        ta_next.ctrl[dtio_pkg::CR_LOAD] = 1'b0;
                    end
                    default: begin
                        tb_next.ctrl = s_data.write_data;
                        tb_next.run  = s_data.write_data[dtio_pkg::CR_START];
                        if ((!tb_reg.ctrl[dtio_pkg::CR_START] &&
                             s_data.write_data[dtio_pkg::CR_START]) ||
                            s_data.write_data[dtio_pkg::CR_LOAD])
                            tb_next.count = latch_b_reg;
                        tb_next.ctrl[dtio_pkg::CR_LOAD] = 1'b0;
                    end
                endcase
            end
            default: begin
                pins_a_next  = s_data.port_a_pins;
                pins_b_next  = s_data.port_b_pins;
                sp_now_next  = s_data.sp_level;
                cnt_now_next = s_data.cnt_level;
                if (s_data.cnt_level && !cnt_now_reg && !ta_reg.ctrl[dtio_pkg::CRA_SPOUT]) begin
                    shifter_next = {shifter_reg[6:0], s_data.sp_level};
                    scount_next  = scount_reg + 4'd1;
                    if (scount_next == 4'd8) begin
                        sdr_next = shifter_next;
                        raise = raise | dtio_pkg::IRQ_SDR;
                        shifter_next = 8'd0;
                        scount_next = 4'd0;
                    end
                end
                if (flag_prev_reg && !s_data.flag_level) raise = raise | dtio_pkg::IRQ_FLAG;
                flag_prev_next = s_data.flag_level;
            end
        endcase

        // raising drops bits 6..5 and re-evaluates the master bit
        if (icr_read) begin
            ilatch_next = 8'd0;
        end else if (raise != 5'd0 || recompute) begin
            ilatch_next = {|((base_latch[4:0] | raise) & ien_next), 2'b00,
                           base_latch[4:0] | raise};
            if (recompute && raise == 5'd0)
                ilatch_next[6:0] = base_latch[6:0];
        end else begin
            ilatch_next = base_latch;
        end

        res.irq_active       = ilatch_next[7];
        res.port_a_drive     = pa_out_next;
        res.port_a_direction = dir_a_next;
        res.port_b_drive     = pb_out_next;
        res.port_b_direction = dir_b_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_out_reg <= '0; pb_out_reg <= '0; dir_a_reg <= '0; dir_b_reg <= '0;
            pins_a_reg <= 8'hFF; pins_b_reg <= 8'hFF;
            latch_a_reg <= '0; latch_b_reg <= '0;
            ta_reg <= '0; tb_reg <= '0;
            for (int i = 0; i < 4; i++) tod_reg[i] <= '0;
            sdr_reg <= '0; shifter_reg <= '0; scount_reg <= '0; sloaded_reg <= 1'b0;
            ien_reg <= '0; ilatch_reg <= '0;
            cnt_now_reg <= 1'b1; cnt_prev_reg <= 1'b1; sp_now_reg <= 1'b0;
            flag_prev_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                pa_out_reg <= pa_out_next; pb_out_reg <= pb_out_next;
                dir_a_reg <= dir_a_next;   dir_b_reg <= dir_b_next;
                pins_a_reg <= pins_a_next; pins_b_reg <= pins_b_next;
                latch_a_reg <= latch_a_next; latch_b_reg <= latch_b_next;
                ta_reg <= ta_next; tb_reg <= tb_next;
                for (int i = 0; i < 4; i++)
                    if (tod_wsel[i]) tod_reg[i] <= s_data.write_data;
                sdr_reg <= sdr_next; shifter_reg <= shifter_next;
                scount_reg <= scount_next; sloaded_reg <= sloaded_next;
                ien_reg <= ien_next; ilatch_reg <= ilatch_next;
                cnt_now_reg <= cnt_now_next; cnt_prev_reg <= cnt_prev_next;
                sp_now_reg <= sp_now_next; flag_prev_reg <= flag_prev_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) m_data_reg <= res;
    end

`ifndef ASSERT_OFF
    // master bit only set when an enabled source is pending
    a_master: assert property (@(posedge aclk) disable iff (!aresetn)
        ilatch_reg[7] |-> ((ilatch_reg[4:0] & ien_reg) != 5'd0))
        else $error("irq master set with no enabled source");
    // shift count never passes eight
    a_scount: assert property (@(posedge aclk) disable iff (!aresetn)
        scount_reg <= 4'd8)
        else $error("shift count out of range");
    // timer a run flag always matches its start bit
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ta_reg.run == ta_reg.ctrl[dtio_pkg::CR_START])
        else $error("timer a run flag disagrees with start bit");
`endif

endmodule

// ===== verif/dual_timer_io_peripheral_checker.sv =====
// dual_timer_io_peripheral_checker: watches both channels, predicts each result, compares
// depends on dtio_pkg
`timescale 1ns / 1ps

module dual_timer_io_peripheral_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dtio_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dtio_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending_count,
    output int                  result_count
);

    localparam logic [7:0] SRC_MASK = 8'h1F;
    localparam logic [7:0] MASTER   = 8'h80;

    logic [7:0]  pa_out, pb_out, ddra, ddrb, pa_pins, pb_pins;
    logic [15:0] cnt_a, lat_a, vw_a, cnt_b, lat_b, vw_b;
    logic        go_a, go_b;
    logic [7:0]  cra, crb;
    logic [7:0]  tod [4];
    logic [7:0]  sdr, shreg;
    logic [3:0]  shcnt;
    logic        shload;
    logic [4:0]  ien;
    logic [7:0]  ilatch;
    logic        cnt_lv, cnt_old, sp_lv, flag_old;

    dtio_pkg::out_item_t expected_results [$];

    task automatic model_reset();
        pa_out = 0; pb_out = 0; ddra = 0; ddrb = 0; pa_pins = 8'hFF; pb_pins = 8'hFF;
        cnt_a = 0; lat_a = 0; vw_a = 0; cnt_b = 0; lat_b = 0; vw_b = 0;
        go_a = 0; go_b = 0; cra = 0; crb = 0;
        for (int i = 0; i < 4; i++) tod[i] = 0;
        sdr = 0; shreg = 0; shcnt = 0; shload = 0; ien = 0; ilatch = 0;
        cnt_lv = 1; cnt_old = 1; sp_lv = 0; flag_old = 1;
    endtask

    function automatic void refresh_master();
        if ((ilatch & {3'b0, ien} & SRC_MASK) != 0) ilatch = ilatch | MASTER;
        else ilatch = ilatch & 8'h7F;
    endfunction

    function automatic void raise_irq(logic [4:0] src);
        ilatch = (ilatch & SRC_MASK) | {3'b0, src};
        refresh_master();
    endfunction

    function automatic logic decrement(ref logic [15:0] c, input logic [15:0] lat,
                                       ref logic [15:0] vw, ref logic run,
                                       ref logic [7:0] cr, input logic [4:0] src);
        logic under;
        under = (c == 0);
        c = c - 16'd1;
        if (under) begin
            raise_irq(src);
            c = lat;
            if (cr[dtio_pkg::CR_ONESHOT]) begin
                run = 0;
                cr[dtio_pkg::CR_START] = 0;
            end
        end
        vw = c;
        return under;
    endfunction

    function automatic void write_control(input logic [7:0] v, ref logic [7:0] cr,
                                          ref logic [15:0] c, input logic [15:0] lat,
                                          ref logic run);
        logic [7:0] old;
        old = cr;
        cr = v;
        if (!old[dtio_pkg::CR_START] && v[dtio_pkg::CR_START]) c = lat;
        run = v[dtio_pkg::CR_START];
        if (v[dtio_pkg::CR_LOAD]) begin
            c = lat;
            cr[dtio_pkg::CR_LOAD] = 0;
        end
    endfunction

    function automatic dtio_pkg::out_item_t predict_result(dtio_pkg::in_item_t it);
        dtio_pkg::out_item_t r;
        logic edge_seen, ua, dec_b, old_cnt;
        logic [7:0] p;
        r = '0;
        r.read_data = 8'hFF;
        ua = 0;
        dec_b = 0;
        case (dtio_pkg::cmd_t'(it.command))
            dtio_pkg::CMD_TICK: begin
                edge_seen = cnt_lv && !cnt_old;
                if (go_a && (!cra[dtio_pkg::CRA_CNTMODE] || edge_seen))
                    ua = decrement(cnt_a, lat_a, vw_a, go_a, cra, dtio_pkg::IRQ_TA);
                if (cra[dtio_pkg::CRA_SPOUT] && shload && ua) begin
                    r.shift_out_bit = shreg[7];
                    r.shift_out_strobe = 1;
                    shreg = shreg << 1;
                    shcnt = shcnt + 4'd1;
                    if (shcnt >= 8) begin
                        r.shift_out_done = 1;
                        raise_irq(dtio_pkg::IRQ_SDR);
                        shcnt = 0;
                        shload = 0;
                    end
                end
                if (go_b) begin
                    case (crb[6:5])
                        dtio_pkg::TB_CLK: dec_b = 1;
                        dtio_pkg::TB_CNT: dec_b = edge_seen;
                        dtio_pkg::TB_TA:  dec_b = ua;
                        default:          dec_b = ua && cnt_lv;
                    endcase
                end
                if (dec_b)
                    void'(decrement(cnt_b, lat_b, vw_b, go_b, crb, dtio_pkg::IRQ_TB));
                cnt_old = cnt_lv;
            end
            dtio_pkg::CMD_READ: begin
                case (dtio_pkg::reg_addr_t'(it.address))
                    dtio_pkg::REG_PRA:  r.read_data = (pa_out & ddra) | (pa_pins & ~ddra);
                    dtio_pkg::REG_PRB:  r.read_data = (pb_out & ddrb) | (pb_pins & ~ddrb);
                    dtio_pkg::REG_DDRA: r.read_data = ddra;
                    dtio_pkg::REG_DDRB: r.read_data = ddrb;
                    dtio_pkg::REG_TALO: r.read_data = vw_a[7:0];
                    dtio_pkg::REG_TAHI: r.read_data = vw_a[15:8];
                    dtio_pkg::REG_TBLO: r.read_data = vw_b[7:0];
                    dtio_pkg::REG_TBHI: r.read_data = vw_b[15:8];
                    dtio_pkg::REG_TOD0, dtio_pkg::REG_TOD1,
                    dtio_pkg::REG_TOD2, dtio_pkg::REG_TOD3:
                        r.read_data = tod[it.address[1:0]];
                    dtio_pkg::REG_SDR:  r.read_data = sdr;
                    dtio_pkg::REG_ICR: begin
                        p = ilatch & SRC_MASK;
                        r.read_data = p;
                        if ((p & {3'b0, ien}) != 0) r.read_data = p | MASTER;
                        ilatch = 0;
                    end
                    dtio_pkg::REG_CRA:  r.read_data = cra;
                    default:            r.read_data = crb;
                endcase
            end
            dtio_pkg::CMD_WRITE: begin
                case (dtio_pkg::reg_addr_t'(it.address))
                    dtio_pkg::REG_PRA:  pa_out = it.write_data;
                    dtio_pkg::REG_PRB:  pb_out = it.write_data;
                    dtio_pkg::REG_DDRA: ddra = it.write_data;
                    dtio_pkg::REG_DDRB: ddrb = it.write_data;
                    dtio_pkg::REG_TALO: begin
                        vw_a[7:0] = it.write_data;
                        lat_a[7:0] = it.write_data;
                        if (!go_a) cnt_a[7:0] = it.write_data;
                    end
                    dtio_pkg::REG_TAHI: begin
                        vw_a[15:8] = it.write_data;
                        lat_a = vw_a;
                        if (!go_a) cnt_a = lat_a;
                    end
                    dtio_pkg::REG_TBLO: begin
                        vw_b[7:0] = it.write_data;
                        lat_b[7:0] = it.write_data;
                        if (!go_b) cnt_b[7:0] = it.write_data;
                    end
                    dtio_pkg::REG_TBHI: begin
                        vw_b[15:8] = it.write_data;
                        lat_b = vw_b;
                        if (!go_b) cnt_b = lat_b;
                    end
                    dtio_pkg::REG_TOD0, dtio_pkg::REG_TOD1,
                    dtio_pkg::REG_TOD2, dtio_pkg::REG_TOD3:
                        tod[it.address[1:0]] = it.write_data;
                    dtio_pkg::REG_SDR: begin
                        sdr = it.write_data;
                        shreg = it.write_data;
                        shcnt = 0;
                        shload = 1;
                        cnt_old = cnt_lv;
                    end
                    dtio_pkg::REG_ICR: begin
                        if (it.write_data[7]) ien = ien | it.write_data[4:0];
                        else ien = ien & ~it.write_data[4:0];
                        refresh_master();
                    end
                    dtio_pkg::REG_CRA:
                        write_control(it.write_data, cra, cnt_a, lat_a, go_a);
                    default:
                        write_control(it.write_data, crb, cnt_b, lat_b, go_b);
                endcase
            end
            default: begin
                old_cnt = cnt_lv;
                pa_pins = it.port_a_pins;
                pb_pins = it.port_b_pins;
                sp_lv = it.sp_level;
                cnt_lv = it.cnt_level;
                if (cnt_lv && !old_cnt && !cra[dtio_pkg::CRA_SPOUT]) begin
                    shreg = {shreg[6:0], sp_lv};
                    shcnt = shcnt + 4'd1;
                    if (shcnt == 8) begin
                        sdr = shreg;
                        raise_irq(dtio_pkg::IRQ_SDR);
                        shreg = 0;
                        shcnt = 0;
                    end
                end
                if (flag_old && !it.flag_level) raise_irq(dtio_pkg::IRQ_FLAG);
                flag_old = it.flag_level;
            end
        endcase
        r.irq_active = ilatch[7];
        r.port_a_drive = pa_out;
        r.port_a_direction = ddra;
        r.port_b_drive = pb_out;
        r.port_b_direction = ddrb;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0h want %0h", result_count, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        model_reset();
    end

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        dtio_pkg::out_item_t want;
        if (aresetn) begin
            // result side first: a transfer in this cycle cannot be the one just accepted
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("result %0d arrived with nothing expected", result_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.read_data != want.read_data)
                        report_mismatch("read_data", m_data.read_data, want.read_data);
                    if (m_data.irq_active != want.irq_active)
                        report_mismatch("irq_active", m_data.irq_active, want.irq_active);
                    if (m_data.shift_out_bit != want.shift_out_bit)
                        report_mismatch("shift_out_bit", m_data.shift_out_bit,
                                        want.shift_out_bit);
                    if (m_data.shift_out_strobe != want.shift_out_strobe)
                        report_mismatch("shift_out_strobe", m_data.shift_out_strobe,
                                        want.shift_out_strobe);
                    if (m_data.shift_out_done != want.shift_out_done)
                        report_mismatch("shift_out_done", m_data.shift_out_done,
                                        want.shift_out_done);
                    if (m_data.port_a_drive != want.port_a_drive)
                        report_mismatch("port_a_drive", m_data.port_a_drive, want.port_a_drive);
                    if (m_data.port_a_direction != want.port_a_direction)
                        report_mismatch("port_a_direction", m_data.port_a_direction,
                                        want.port_a_direction);
                    if (m_data.port_b_drive != want.port_b_drive)
                        report_mismatch("port_b_drive", m_data.port_b_drive, want.port_b_drive);
                    if (m_data.port_b_direction != want.port_b_direction)
                        report_mismatch("port_b_direction", m_data.port_b_direction,
                                        want.port_b_direction);
                end
                result_count++;
            end
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_data));
        end
    end
endmodule

// ===== verif/dual_timer_io_peripheral_test.sv =====
// dual_timer_io_peripheral_test: stimulus, idling phases and verdict
// depends on dtio_pkg, dual_timer_io_peripheral and dual_timer_io_peripheral_checker
`timescale 1ns / 1ps

module dual_timer_io_peripheral_test;

    localparam int CYCLE_LIMIT = 200000;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_valid = 0;
    logic                s_ready;
    dtio_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 0;
    dtio_pkg::out_item_t m_data;
    int        fail_count, pending_count, result_count;
    int        cycle_count = 0;
    int        send_idle_pct = 33;
    int        recv_idle_pct = 58;
    int        hold_cycles = 0;
    logic      cnt_line = 1;

    always #5 aclk = ~aclk;

    dual_timer_io_peripheral uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    dual_timer_io_peripheral_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("dual_timer_io_peripheral_test: FAIL");
            $finish;
        end
    end

    // receiver: random idling, or a long hold-off while hold_cycles counts down
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid drops only when the sender idles, so back to back transfers keep it high
    task automatic send_item(dtio_pkg::in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic bus_op(dtio_pkg::cmd_t c, dtio_pkg::reg_addr_t a, logic [7:0] d);
        dtio_pkg::in_item_t it;
        it = '0;
        it.command = c;
        it.address = a;
        it.write_data = d;
        it.port_a_pins = 8'($urandom);
        it.port_b_pins = 8'($urandom);
        it.cnt_level = 1'($urandom);
        it.sp_level = 1'($urandom);
        it.flag_level = 1'($urandom);
        send_item(it);
    endtask

    task automatic line_op(logic [7:0] pa, logic [7:0] pb, logic cnt, logic sp, logic flg);
        dtio_pkg::in_item_t it;
        it = '0;
        it.command = dtio_pkg::CMD_LINES;
        it.address = 4'($urandom);
        it.write_data = 8'($urandom);
        it.port_a_pins = pa;
        it.port_b_pins = pb;
        it.cnt_level = cnt;
        it.sp_level = sp;
        it.flag_level = flg;
        cnt_line = cnt;
        send_item(it);
    endtask

    // mostly ticks and register traffic on a small timer setup, some line changes
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            bus_op(dtio_pkg::CMD_TICK, dtio_pkg::reg_addr_t'(4'($urandom)), 8'($urandom));
        else if (pick < 60)
            bus_op(dtio_pkg::CMD_READ, dtio_pkg::reg_addr_t'(4'($urandom)), 8'($urandom));
        else if (pick < 70)
            line_op(8'($urandom), 8'($urandom), ~cnt_line, 1'($urandom), 1'($urandom));
        else if (pick < 75)
            line_op(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 82)
            bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::reg_addr_t'(4'($urandom_range(4, 7))),
                   8'($urandom_range(0, 6)));
        else if (pick < 88)
            bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::reg_addr_t'(4'($urandom_range(14, 15))),
                   8'($urandom));
        else
            bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::reg_addr_t'(4'($urandom)), 8'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: ports, timers, serial out, flag, interrupt control
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_DDRA, 8'hFF);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_PRA, 8'hA5);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_DDRB, 8'h00);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_PRB, 8'hFF);
        line_op(8'h00, 8'hFF, 1, 1, 1);
        bus_op(dtio_pkg::CMD_READ, dtio_pkg::REG_PRA, 0);
        bus_op(dtio_pkg::CMD_READ, dtio_pkg::REG_PRB, 0);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_ICR, 8'h9F);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_TALO, 8'h01);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_TAHI, 8'h00);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_TBHI, 8'hFF);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_SDR, 8'hC3);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_CRA, 8'h51);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_CRB, 8'h59);
        for (int i = 0; i < 6; i++) bus_op(dtio_pkg::CMD_TICK, dtio_pkg::REG_PRA, 0);
        bus_op(dtio_pkg::CMD_READ, dtio_pkg::REG_ICR, 0);
        bus_op(dtio_pkg::CMD_READ, dtio_pkg::REG_TALO, 0);
        line_op(8'hFF, 8'h00, 0, 0, 0);
        bus_op(dtio_pkg::CMD_READ, dtio_pkg::REG_ICR, 0);
        bus_op(dtio_pkg::CMD_WRITE, dtio_pkg::REG_TOD3, 8'hFF);

        for (int n = 0; n < 1050; n++) begin
            if (n == 350) begin
                send_idle_pct = 58;
                recv_idle_pct = 33;
            end
            if (n == 700) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_cycles <= 300;
            end
            random_item();
        end
        s_valid <= 0;

        while (pending_count != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        $display("covered %0d results over ports, both timers, serial shifter and interrupts",
                 result_count);
        $display("three idling phases and one long receiver hold-off were applied");
        if (fail_count == 0) $display("dual_timer_io_peripheral_test: PASS");
        else $display("dual_timer_io_peripheral_test: FAIL");
        $finish;
    end
endmodule
